@@ rtl/bnt_pkg.sv @@
// ----------------------------------------------------------------------------
// bnt_pkg: shared constants for the bucketed name table
// Command and status codes, name word width, letter bounds, bucket count, row width and entry type.
// ----------------------------------------------------------------------------
package bnt_pkg;

  localparam int unsigned WORD_W = 56;

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_FIND    = 2'd1;
  localparam logic [1:0] CMD_DELETE  = 2'd2;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_FOUND     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_DELETED   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_BAD_FIRST = 3'd5;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  localparam int unsigned BUCKETS = 26;
  localparam int unsigned ROW_W   = 5;

  typedef logic [4*WORD_W-1:0] entry_t;

endpackage

@@ rtl/bucketed_name_table_core.sv @@
// ----------------------------------------------------------------------------
// bucketed_name_table_core
// Name-pair table in 26 buckets keyed by the first letter of the first name.
// ----------------------------------------------------------------------------
// One command per transaction. busy rises the cycle after start is taken; the
// single result strobe comes in the first cycle with busy low again, and a new
// start can be taken in that same cycle. An insert does a read and a write-back
// per used slot of the bucket through the registered slot memory, plus the head
// write; a find does one read and compare per slot scanned; a delete does the
// scan, then a read and a write per slot closed up, and then stores the new
// fill. A bad letter, an unknown command, a full bucket or a find or delete in
// an empty bucket goes from decode straight to done. The result is shown for
// one cycle and cannot be stalled.
module bucketed_name_table_core #(
  parameter int unsigned DEPTH      = 8,
  parameter int unsigned NAME_CHARS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [55:0] in_first_name_head,
  input  logic [55:0] in_first_name_tail,
  input  logic [55:0] in_last_name_head,
  input  logic [55:0] in_last_name_tail,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [4:0]  out_row,
  output logic [2:0]  out_place
);

  localparam int unsigned W      = bnt_pkg::WORD_W;
  localparam int unsigned FW     = $clog2(DEPTH + 1);
  localparam int unsigned SLOTS  = bnt_pkg::BUCKETS * DEPTH;
  localparam int unsigned AW     = $clog2(SLOTS);
  localparam int unsigned HEAD_N = (NAME_CHARS > 7) ? 7 : NAME_CHARS;
  localparam int unsigned TAIL_N = (NAME_CHARS > 7) ? NAME_CHARS - 7 : 0;
  localparam logic [W-1:0] HEAD_M =
    (HEAD_N == 0) ? '0 : ~({W{1'b1}} >> (8 * HEAD_N));
  localparam logic [W-1:0] TAIL_M =
    (TAIL_N == 0) ? '0 : ~({W{1'b1}} >> (8 * TAIL_N));

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_CLOSE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  cmd_r;
  bnt_pkg::entry_t key_r;
  logic [4:0]  row_r;
  logic        bad_r;
  logic [FW-1:0] fill_r;
  logic [FW-1:0] fill_cur;
  logic [FW-1:0] idx_r, idx_nxt;
  logic [FW-1:0] hit_r;
  logic          rd_pend_r;
  logic [2:0]  st_r, st_nxt;
  logic [2:0]  place_r;
  logic        vld_r;

  logic [FW-1:0] fill_mem [bnt_pkg::BUCKETS];

  bnt_pkg::entry_t slot_mem [SLOTS];
  bnt_pkg::entry_t rd_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  bnt_pkg::entry_t wr_data;

  logic [7:0] ch, chl;
  logic       letter;
  logic       hit;
  logic [AW-1:0] base;

  assign ch     = in_first_name_head[55:48];
  assign letter = (ch >= bnt_pkg::CH_UPPER_A && ch <= bnt_pkg::CH_UPPER_Z) ||
                  (ch >= bnt_pkg::CH_LOWER_A && ch <= bnt_pkg::CH_LOWER_Z);
  assign chl    = ch | 8'h20;
  assign base   = AW'(row_r) * AW'(DEPTH);
  assign fill_cur = fill_mem[row_r];

  assign hit = ((rd_q[4*W-1:3*W] & HEAD_M) == key_r[4*W-1:3*W]) &&
               ((rd_q[3*W-1:2*W] & TAIL_M) == key_r[3*W-1:2*W]) &&
               ((rd_q[2*W-1:W]   & HEAD_M) == key_r[2*W-1:W]) &&
               ((rd_q[W-1:0]     & TAIL_M) == key_r[W-1:0]);

  always_ff @(posedge clk) begin
    if (rd_en) rd_q <= slot_mem[rd_addr];
    if (wr_en) slot_mem[wr_addr] <= wr_data;
  end

  // next state, status and memory control
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    st_nxt    = st_r;
    rd_en     = 1'b0;
    rd_addr   = base;
    wr_en     = 1'b0;
    wr_addr   = base;
    wr_data   = rd_q;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DEC;
      end
      S_DEC: begin
        if (cmd_r == bnt_pkg::CMD_UNKNOWN) begin
          st_nxt = bnt_pkg::ST_NOT_FOUND;
          state_nxt = S_DONE;
        end else if (bad_r) begin
          st_nxt = bnt_pkg::ST_BAD_FIRST;
          state_nxt = S_DONE;
        end else if (cmd_r == bnt_pkg::CMD_INSERT) begin
          if (fill_cur >= FW'(DEPTH)) begin
            st_nxt = bnt_pkg::ST_FULL;
            state_nxt = S_DONE;
          end else begin
            st_nxt  = bnt_pkg::ST_INSERTED;
            idx_nxt = fill_cur;
            state_nxt = S_SHIFT;
          end
        end else begin
          st_nxt  = bnt_pkg::ST_NOT_FOUND;
          idx_nxt = '0;
          state_nxt = (fill_cur == '0) ? S_DONE : S_SCAN;
        end
      end
      S_SHIFT: begin
        // read slot idx-1, next cycle write it to idx; idx 0 takes the key
        if (idx_r == '0) begin
          wr_en   = 1'b1;
          wr_data = key_r;
          state_nxt = S_DONE;
        end else if (!rd_pend_r) begin
          rd_en   = 1'b1;
          rd_addr = base + AW'(idx_r - 1'b1);
        end else begin
          wr_en   = 1'b1;
          wr_addr = base + AW'(idx_r);
          idx_nxt = idx_r - 1'b1;
        end
      end
      S_SCAN: begin
        if (!rd_pend_r) begin
          rd_en   = 1'b1;
          rd_addr = base + AW'(idx_r);
        end else if (hit) begin
          if (cmd_r == bnt_pkg::CMD_FIND) begin
            st_nxt = bnt_pkg::ST_FOUND;
            state_nxt = S_DONE;
          end else begin
            st_nxt = bnt_pkg::ST_DELETED;
            state_nxt = S_CLOSE;
          end
        end else if (idx_r + 1'b1 >= fill_r) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_CLOSE: begin
        // read slot idx+1, next cycle write it to idx
        if (idx_r + 1'b1 >= fill_r) begin
          state_nxt = S_DONE;
        end else if (!rd_pend_r) begin
          rd_en   = 1'b1;
          rd_addr = base + AW'(idx_r + 1'b1);
        end else begin
          wr_en   = 1'b1;
          wr_addr = base + AW'(idx_r);
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_pend_r <= 1'b0;
      vld_r     <= 1'b0;
      for (int i = 0; i < bnt_pkg::BUCKETS; i++) fill_mem[i] <= '0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      st_r      <= st_nxt;
      rd_pend_r <= rd_en;
      vld_r     <= (state_r == S_DONE);
      if (state_r == S_IDLE && start) begin
        cmd_r   <= in_command;
        key_r   <= {in_first_name_head & HEAD_M, in_first_name_tail & TAIL_M,
                    in_last_name_head & HEAD_M, in_last_name_tail & TAIL_M};
        bad_r   <= !letter;
        row_r   <= (letter && in_command != bnt_pkg::CMD_UNKNOWN) ?
                   5'(chl - bnt_pkg::CH_LOWER_A) : 5'd0;
      end
      if (state_r == S_DEC) fill_r <= fill_cur;
      if (state_r == S_SCAN && rd_pend_r && hit) hit_r <= idx_r;
      if (state_r == S_SHIFT && idx_r == '0) fill_mem[row_r] <= fill_r + 1'b1;
      if (state_r == S_CLOSE && idx_r + 1'b1 >= fill_r)
        fill_mem[row_r] <= fill_r - 1'b1;
      if (state_r == S_DONE)
        place_r <= (st_r == bnt_pkg::ST_FOUND || st_r == bnt_pkg::ST_DELETED) ?
                   3'(hit_r) : 3'd0;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = vld_r;
  assign out_status = st_r;
  assign out_row    = row_r;
  assign out_place  = place_r;

`ifndef SYNTHESIS
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held two cycles");
  a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command accepted but block not busy");
  a_status_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= bnt_pkg::ST_BAD_FIRST)
    else $error("status code out of range");
`endif

endmodule

@@ bench/bucketed_name_table_core_test.sv @@
// ----------------------------------------------------------------------------
// bucketed_name_table_core_test
// Self-checking bench for the bucketed name table. A directed table covers bad
// first letters, the unknown command, empty, full and boundary buckets and
// head, middle and tail deletes; random traffic from a small name pool then
// drives inserts, finds, deletes and unknown commands deep into the buckets.
// Each result is checked against its typed reply or the behavioral table copy.
// ----------------------------------------------------------------------------
module bucketed_name_table_core_test;

  localparam int unsigned DEPTH      = 8;
  localparam int unsigned NAME_CHARS = 14;
  localparam int unsigned RAND_ITEMS = 650;
  localparam int unsigned POOL_SIZE  = 48;
  localparam int unsigned IDLE_LIMIT = 4000;

  localparam logic [55:0] HEAD_MASK = (NAME_CHARS >= 7) ? {56{1'b1}} :
                                      ~({56{1'b1}} >> (8 * NAME_CHARS));
  localparam logic [55:0] TAIL_MASK = (NAME_CHARS >= 14) ? {56{1'b1}} :
                                      (NAME_CHARS <= 7) ? 56'h0 :
                                      ~({56{1'b1}} >> (8 * (NAME_CHARS - 7)));

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] row;
    logic [2:0] place;
  } reply_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [55:0] fh, ft, lh, lt;
    bit          typed;
    reply_t      reply;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = bnt_pkg::CMD_INSERT;
  logic [55:0] in_first_name_head = '0;
  logic [55:0] in_first_name_tail = '0;
  logic [55:0] in_last_name_head = '0;
  logic [55:0] in_last_name_tail = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [4:0]  out_row;
  logic [2:0]  out_place;

  // behavioral copy of the table
  int unsigned bucket_used [bnt_pkg::BUCKETS];
  logic [55:0] slot_fh [bnt_pkg::BUCKETS][DEPTH];
  logic [55:0] slot_ft [bnt_pkg::BUCKETS][DEPTH];
  logic [55:0] slot_lh [bnt_pkg::BUCKETS][DEPTH];
  logic [55:0] slot_lt [bnt_pkg::BUCKETS][DEPTH];

  reply_t      pending_replies [$];
  plan_row_t   plan [$];
  logic [55:0] pool_fh [POOL_SIZE];
  logic [55:0] pool_ft [POOL_SIZE];
  logic [55:0] pool_lh [POOL_SIZE];
  logic [55:0] pool_lt [POOL_SIZE];
  int unsigned fails = 0;
  int unsigned replies_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned sender_idle_pct = 35;

  bucketed_name_table_core #(.DEPTH(DEPTH), .NAME_CHARS(NAME_CHARS)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command),
    .in_first_name_head(in_first_name_head), .in_first_name_tail(in_first_name_tail),
    .in_last_name_head(in_last_name_head), .in_last_name_tail(in_last_name_tail),
    .out_valid(out_valid), .out_status(out_status), .out_row(out_row),
    .out_place(out_place)
  );

  always #1 clk = ~clk;

  function automatic logic [55:0] pack_name(logic [7:0] ch, logic [47:0] rest);
    return {ch, rest};
  endfunction

  function automatic logic [55:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // apply one command to the table copy and return the reply it gives
  function automatic reply_t table_apply(logic [1:0] cmd, logic [55:0] fh,
                                         logic [55:0] ft, logic [55:0] lh,
                                         logic [55:0] lt);
    reply_t      r;
    logic [7:0]  c;
    int unsigned row, used, hit;
    r = '{status: bnt_pkg::ST_NOT_FOUND, row: 5'd0, place: 3'd0};
    fh &= HEAD_MASK; lh &= HEAD_MASK; ft &= TAIL_MASK; lt &= TAIL_MASK;
    c = fh[55:48];
    if (cmd != bnt_pkg::CMD_INSERT && cmd != bnt_pkg::CMD_FIND &&
        cmd != bnt_pkg::CMD_DELETE) return r;
    if (c >= bnt_pkg::CH_UPPER_A && c <= bnt_pkg::CH_UPPER_Z) c = c + 8'd32;
    if (c < bnt_pkg::CH_LOWER_A || c > bnt_pkg::CH_LOWER_Z) begin
      r.status = bnt_pkg::ST_BAD_FIRST;
      return r;
    end
    row = c - bnt_pkg::CH_LOWER_A;
    used = bucket_used[row];
    r.row = row[4:0];
    if (cmd == bnt_pkg::CMD_INSERT) begin
      if (used >= DEPTH) begin
        r.status = bnt_pkg::ST_FULL;
      end else begin
        for (int i = used; i > 0; i--) begin
          slot_fh[row][i] = slot_fh[row][i-1]; slot_ft[row][i] = slot_ft[row][i-1];
          slot_lh[row][i] = slot_lh[row][i-1]; slot_lt[row][i] = slot_lt[row][i-1];
        end
        slot_fh[row][0] = fh; slot_ft[row][0] = ft;
        slot_lh[row][0] = lh; slot_lt[row][0] = lt;
        bucket_used[row] = used + 1;
        r.status = bnt_pkg::ST_INSERTED;
      end
      return r;
    end
    hit = used;
    for (int i = 0; i < used; i++) begin
      if (slot_fh[row][i] == fh && slot_ft[row][i] == ft &&
          slot_lh[row][i] == lh && slot_lt[row][i] == lt) begin
        hit = i;
        break;
      end
    end
    if (hit < used) begin
      r.place = hit[2:0];
      if (cmd == bnt_pkg::CMD_FIND) begin
        r.status = bnt_pkg::ST_FOUND;
      end else begin
        for (int i = hit; i + 1 < used; i++) begin
          slot_fh[row][i] = slot_fh[row][i+1]; slot_ft[row][i] = slot_ft[row][i+1];
          slot_lh[row][i] = slot_lh[row][i+1]; slot_lt[row][i] = slot_lt[row][i+1];
        end
        bucket_used[row] = used - 1;
        r.status = bnt_pkg::ST_DELETED;
      end
    end
    return r;
  endfunction

  task automatic add_row(logic [1:0] cmd, logic [55:0] fh, logic [55:0] ft,
                         logic [55:0] lh, logic [55:0] lt, bit typed,
                         logic [2:0] st, logic [4:0] row, logic [2:0] place);
    plan_row_t p;
    p.cmd = cmd; p.fh = fh; p.ft = ft; p.lh = lh; p.lt = lt; p.typed = typed;
    p.reply = '{status: st, row: row, place: place};
    plan.push_back(p);
  endtask

  // present one transaction, idling first as the current phase asks
  task automatic send(plan_row_t p);
    reply_t predicted;
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    start <= 1'b1;
    in_command <= p.cmd;
    in_first_name_head <= p.fh; in_first_name_tail <= p.ft;
    in_last_name_head <= p.lh;  in_last_name_tail <= p.lt;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = table_apply(p.cmd, p.fh, p.ft, p.lh, p.lt);
    pending_replies.push_back(p.typed ? p.reply : predicted);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        $error("result with nothing expected: status %0d row %0d place %0d",
               out_status, out_row, out_place);
        fails++;
      end else begin
        reply_t e;
        e = pending_replies.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          fails++;
        end
        if (out_row !== e.row) begin
          $error("row: expected %0d, got %0d", e.row, out_row);
          fails++;
        end
        if (out_place !== e.place) begin
          $error("place: expected %0d, got %0d", e.place, out_place);
          fails++;
        end
      end
    end
  end

  // watchdog: count cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    plan_row_t   p;
    int unsigned k, sel;
    for (int r = 0; r < bnt_pkg::BUCKETS; r++) bucket_used[r] = 0;

    // bad first letters around the letter ranges, unknown command, empty find
    add_row(bnt_pkg::CMD_INSERT, 56'h0, 56'h0, 56'h0, 56'h0, 1,
            bnt_pkg::ST_BAD_FIRST, 0, 0);
    add_row(bnt_pkg::CMD_FIND, pack_name(8'h40, 48'h1), 56'h0, 56'h0, 56'h0, 1,
            bnt_pkg::ST_BAD_FIRST, 0, 0);
    add_row(bnt_pkg::CMD_DELETE, pack_name(8'h5B, 48'h1), 56'h0, 56'h0, 56'h0, 1,
            bnt_pkg::ST_BAD_FIRST, 0, 0);
    add_row(bnt_pkg::CMD_INSERT, pack_name(8'h60, 48'h1), 56'h0, 56'h0, 56'h0, 1,
            bnt_pkg::ST_BAD_FIRST, 0, 0);
    add_row(bnt_pkg::CMD_INSERT, pack_name(8'h7B, 48'h1), 56'h0, 56'h0, 56'h0, 1,
            bnt_pkg::ST_BAD_FIRST, 0, 0);
    add_row(bnt_pkg::CMD_INSERT, {56{1'b1}}, {56{1'b1}}, {56{1'b1}}, {56{1'b1}}, 1,
            bnt_pkg::ST_BAD_FIRST, 0, 0);
    add_row(bnt_pkg::CMD_UNKNOWN, pack_name(8'h61, 48'h0), 56'h0, 56'h0, 56'h0, 1,
            bnt_pkg::ST_NOT_FOUND, 0, 0);
    add_row(bnt_pkg::CMD_FIND, pack_name(8'h61, 48'h0), 56'h0, 56'h0, 56'h0, 1,
            bnt_pkg::ST_NOT_FOUND, 0, 0);
    add_row(bnt_pkg::CMD_INSERT, pack_name(8'h41, {48{1'b1}}), {56{1'b1}}, {56{1'b1}},
            {56{1'b1}}, 1, bnt_pkg::ST_INSERTED, 0, 0);
    add_row(bnt_pkg::CMD_INSERT, pack_name(8'h7A, 48'h0), 56'h0, 56'h0, 56'h0, 1,
            bnt_pkg::ST_INSERTED, 25, 0);
    add_row(bnt_pkg::CMD_FIND, pack_name(8'h41, {48{1'b1}}), {56{1'b1}}, {56{1'b1}},
            {56{1'b1}}, 1, bnt_pkg::ST_FOUND, 0, 0);
    add_row(bnt_pkg::CMD_DELETE, pack_name(8'h41, {48{1'b1}}), {56{1'b1}}, {56{1'b1}},
            {56{1'b1}}, 1, bnt_pkg::ST_DELETED, 0, 0);
    // fill bucket m, then overflow it through the upper-case letter
    for (int n = 1; n <= DEPTH; n++)
      add_row(bnt_pkg::CMD_INSERT, pack_name(8'h6D, 48'(n)), 56'h0, 56'h5, 56'h0, 1,
              bnt_pkg::ST_INSERTED, 12, 0);
    add_row(bnt_pkg::CMD_INSERT, pack_name(8'h4D, 48'h1), 56'h0, 56'h5, 56'h0, 1,
            bnt_pkg::ST_FULL, 12, 0);
    add_row(bnt_pkg::CMD_FIND, pack_name(8'h6D, 48'h1), 56'h0, 56'h5, 56'h0, 1,
            bnt_pkg::ST_FOUND, 12, 7);
    add_row(bnt_pkg::CMD_FIND, pack_name(8'h6D, 48'h1), 56'h0, 56'h6, 56'h0, 0, 0, 0, 0);
    add_row(bnt_pkg::CMD_DELETE, pack_name(8'h6D, 48'h8), 56'h0, 56'h5, 56'h0, 1,
            bnt_pkg::ST_DELETED, 12, 0);
    add_row(bnt_pkg::CMD_DELETE, pack_name(8'h6D, 48'h4), 56'h0, 56'h5, 56'h0, 0, 0, 0, 0);
    add_row(bnt_pkg::CMD_DELETE, pack_name(8'h6D, 48'h1), 56'h0, 56'h5, 56'h0, 0, 0, 0, 0);
    add_row(bnt_pkg::CMD_DELETE, pack_name(8'h6D, 48'h1), 56'h0, 56'h5, 56'h0, 1,
            bnt_pkg::ST_NOT_FOUND, 12, 0);

    // name pool on a few letters of both cases, so buckets fill and match
    for (int i = 0; i < POOL_SIZE; i++) begin
      k = $urandom_range(5);
      pool_fh[i] = pack_name(($urandom_range(1) ? bnt_pkg::CH_UPPER_A :
                                                  bnt_pkg::CH_LOWER_A) + 8'(k),
                             $urandom_range(1) ? 48'(rand_word()) : 48'($urandom_range(3)));
      pool_ft[i] = $urandom_range(1) ? rand_word() : 56'h0;
      pool_lh[i] = $urandom_range(1) ? rand_word() : 56'(i);
      pool_lt[i] = $urandom_range(3) == 0 ? rand_word() : 56'h0;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) send(plan[i]);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS / 3) sender_idle_pct = 68;
      if (i == 2 * RAND_ITEMS / 3) sender_idle_pct = 0;
      sel = $urandom_range(99);
      p.cmd = sel < 40 ? bnt_pkg::CMD_INSERT : sel < 68 ? bnt_pkg::CMD_FIND :
              sel < 95 ? bnt_pkg::CMD_DELETE : bnt_pkg::CMD_UNKNOWN;
      p.typed = 0;
      p.reply = '0;
      if ($urandom_range(9) == 0) begin
        // noise: any bit pattern on every field
        p.fh = rand_word(); p.ft = rand_word(); p.lh = rand_word(); p.lt = rand_word();
      end else begin
        k = $urandom_range(POOL_SIZE - 1);
        p.fh = pool_fh[k]; p.ft = pool_ft[k]; p.lh = pool_lh[k]; p.lt = pool_lt[k];
      end
      send(p);
    end
    start <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d directed and %0d random commands, %0d results checked",
             plan.size(), RAND_ITEMS, replies_seen);
    $display("with bad letters, unknown commands, full buckets and head/middle/tail deletes");
    if (fails == 0 && pending_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bnt_pkg.sv
rtl/bucketed_name_table_core.sv
bench/bucketed_name_table_core_test.sv
